// ----- hw/rtl/rti_pkg.sv -----
// Shared types and constants for the ray/triangle intersection unit.
package rti_pkg;

  localparam int FIELD_W = 63;
  localparam int DIST_W  = 30;
  localparam int EPS_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;

  localparam logic [EPS_W-1:0]  DET_EPSILON_RST = 40'd1;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_c;
    logic [FIELD_W-1:0] vertex_b;
    logic [FIELD_W-1:0] vertex_a;
    logic [FIELD_W-1:0] ray_direction;
    logic [FIELD_W-1:0] ray_origin;
  } ray_word_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
  } result_word_t;

endpackage

// ----- hw/rtl/rti_if.sv -----
// Valid/ready channel interfaces for ray words and result words.
interface rti_ray_if import rti_pkg::*; ();
  logic      valid;
  logic      ready;
  ray_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rti_result_if import rti_pkg::*; ();
  logic         valid;
  logic         ready;
  result_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ray_triangle_intersect_unit.sv -----
// Pipelined fixed-point ray/triangle intersection test.
//
// ray_in carries one word per test: ray origin, direction and the three
// triangle vertices, each three packed signed coordinates (x lowest).
// result carries one word per test: hit flag and distance (zero on miss).
// The user must write registers via cfg_we/cfg_index/cfg_data only while
// idle (not enforced); index 0: determinant threshold, 1: minimum distance.
//
// Throughput: one word per clock unless the receiver stalls the pipeline;
// every stage advances together. Depth: 39 register stages (eight
// arithmetic stages, one restoring-division stage per distance bit, one
// output register). The distance division sets the depth; each stage
// does one wide compare and subtract.
//
// Reset clears all valid bits and loads the register defaults.
// When the receiver holds ready low with a result waiting, the whole
// pipeline holds and ray_in.ready drops; nothing is lost or repeated.
module ray_triangle_intersect_unit import rti_pkg::*; #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  rti_ray_if.sink               ray_in,
  rti_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int D    = C + 1;        // differences
  localparam int H    = 2 * D + 1;    // cross products
  localparam int L    = D + 1;        // low split of a cross product
  localparam int P    = 3 * D + 1;    // dot terms
  localparam int DW   = 3 * D + 3;    // dot sums
  localparam int REMW = DW + DIST_W;  // division remainder
  localparam int NV   = 8 + DIST_W;   // valid bits along the pipeline

  logic [EPS_W-1:0]  det_epsilon;
  logic [DIST_W-1:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon  <= DET_EPSILON_RST;
      min_distance <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DET_EPSILON) det_epsilon <= cfg_data[EPS_W-1:0];
      else if (cfg_index == REG_MIN_DISTANCE) min_distance <= cfg_data[DIST_W-1:0];
    end
  end

  logic adv;
  logic ov;
  result_word_t od;
  assign adv = !ov || result.ready;
  assign ray_in.ready = adv;
  assign result.valid = ov;
  assign result.data  = od;

  // sv[1..8] follow the arithmetic stages, sv[9..NV] the division stages
  logic sv [1:NV];

  // stage 1: edges and offset
  logic signed [D-1:0] s1_d [3], s1_e1 [3], s1_e2 [3], s1_s [3];
  logic signed [D-1:0] ro [3], rd [3], va [3], vb [3], vc [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ro[j] = D'($signed(ray_in.data.ray_origin[j*C +: C]));
      rd[j] = D'($signed(ray_in.data.ray_direction[j*C +: C]));
      va[j] = D'($signed(ray_in.data.vertex_a[j*C +: C]));
      vb[j] = D'($signed(ray_in.data.vertex_b[j*C +: C]));
      vc[j] = D'($signed(ray_in.data.vertex_c[j*C +: C]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s1_d[j]  <= rd[j];
        s1_e1[j] <= vb[j] - va[j];
        s1_e2[j] <= vc[j] - va[j];
        s1_s[j]  <= ro[j] - va[j];
      end
    end
  end

  // stage 2: cross product terms, h = d x e2, q = s x e1
  logic signed [2*D-1:0] hp [3][2], qp [3][2];
  logic signed [D-1:0] s2_d [3], s2_e1 [3], s2_e2 [3], s2_s [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      hp[0][0] <= s1_d[1] * s1_e2[2];  hp[0][1] <= s1_d[2] * s1_e2[1];
      hp[1][0] <= s1_d[2] * s1_e2[0];  hp[1][1] <= s1_d[0] * s1_e2[2];
      hp[2][0] <= s1_d[0] * s1_e2[1];  hp[2][1] <= s1_d[1] * s1_e2[0];
      qp[0][0] <= s1_s[1] * s1_e1[2];  qp[0][1] <= s1_s[2] * s1_e1[1];
      qp[1][0] <= s1_s[2] * s1_e1[0];  qp[1][1] <= s1_s[0] * s1_e1[2];
      qp[2][0] <= s1_s[0] * s1_e1[1];  qp[2][1] <= s1_s[1] * s1_e1[0];
      s2_d <= s1_d;  s2_e1 <= s1_e1;  s2_e2 <= s1_e2;  s2_s <= s1_s;
    end
  end

  // stage 3: cross products
  logic signed [H-1:0] s3_h [3], s3_q [3];
  logic signed [D-1:0] s3_d [3], s3_e1 [3], s3_e2 [3], s3_s [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s3_h[j] <= H'(hp[j][0]) - H'(hp[j][1]);
        s3_q[j] <= H'(qp[j][0]) - H'(qp[j][1]);
      end
      s3_d <= s2_d;  s3_e1 <= s2_e1;  s3_e2 <= s2_e2;  s3_s <= s2_s;
    end
  end

  // stage 4: split dot-product multiplies; order det, un, vn, tn
  logic signed [D-1:0] dx [4][3];
  logic signed [H-1:0] dy [4][3];
  logic signed [D+L:0]   plo [4][3];
  logic signed [2*D-1:0] phi [4][3];

  always_comb begin
    dx[0] = s3_e1;  dy[0] = s3_h;
    dx[1] = s3_s;   dy[1] = s3_h;
    dx[2] = s3_d;   dy[2] = s3_q;
    dx[3] = s3_e2;  dy[3] = s3_q;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          plo[k][j] <= dx[k][j] * $signed({1'b0, dy[k][j][L-1:0]});
          phi[k][j] <= dx[k][j] * $signed(dy[k][j][H-1:L]);
        end
      end
    end
  end

  // stage 5: recombine halves
  logic signed [P-1:0] tm [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          tm[k][j] <= (P'(phi[k][j]) <<< L) + P'(plo[k][j]);
        end
      end
    end
  end

  // stage 6: dot sums
  logic signed [DW-1:0] dsum [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        dsum[k] <= DW'(tm[k][0]) + DW'(tm[k][1]) + DW'(tm[k][2]);
      end
    end
  end

  // stage 7: fold the determinant sign into all numerators
  logic signed [DW-1:0] f_det, f_un, f_vn, f_tn;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dsum[0][DW-1]) begin
        f_det <= -dsum[0];  f_un <= -dsum[1];
        f_vn  <= -dsum[2];  f_tn <= -dsum[3];
      end else begin
        f_det <= dsum[0];   f_un <= dsum[1];
        f_vn  <= dsum[2];   f_tn <= dsum[3];
      end
    end
  end

  // stage 8: range tests, saturation test, division setup
  logic signed [DW:0] uv_sum;
  logic det_bad, u_bad, v_bad, t_bad, sat_c;
  assign uv_sum  = (DW+1)'(f_un) + (DW+1)'(f_vn);
  assign det_bad = (f_det == '0) || (REMW'(f_det) < REMW'(det_epsilon));
  assign u_bad   = f_un[DW-1] || (f_un > f_det);
  assign v_bad   = f_vn[DW-1] || (uv_sum > (DW+1)'(f_det));
  assign t_bad   = f_tn[DW-1] || (f_tn == '0);
  assign sat_c   = REMW'(f_tn) >= (REMW'(f_det) << (DIST_W - FRAC_BITS));

  logic              dok  [0:DIST_W];
  logic              dsat [0:DIST_W];
  logic [DW-1:0]     ddet [0:DIST_W];
  logic [REMW-1:0]   drem [0:DIST_W];
  logic [DIST_W-1:0] dq   [0:DIST_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      dok[0]  <= !(det_bad || u_bad || v_bad || t_bad);
      dsat[0] <= sat_c;
      ddet[0] <= f_det;
      drem[0] <= t_bad ? '0 : (REMW'(f_tn) << FRAC_BITS);
      dq[0]   <= '0;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < DIST_W; i++) begin : g_div
    localparam int SH = DIST_W - 1 - i;
    logic [REMW-1:0] dsh;
    logic            take;
    assign dsh  = REMW'(ddet[i]) << SH;
    assign take = drem[i] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        dok[i+1]  <= dok[i];
        dsat[i+1] <= dsat[i];
        ddet[i+1] <= ddet[i];
        drem[i+1] <= take ? drem[i] - dsh : drem[i];
        dq[i+1]   <= dq[i] | (DIST_W'(take) << SH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 1; n <= NV; n++) sv[n] <= 1'b0;
    end else if (adv) begin
      sv[1] <= ray_in.valid;
      for (int n = 2; n <= NV; n++) sv[n] <= sv[n-1];
    end
  end

  // output register
  logic [DIST_W-1:0] t_fin;
  logic              hit_c;
  assign t_fin = dsat[DIST_W] ? DIST_MAX : dq[DIST_W];
  assign hit_c = dok[DIST_W] && (t_fin > min_distance);

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= sv[NV];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od.hit          <= hit_c;
      od.hit_distance <= hit_c ? t_fin : '0;
    end
  end

  a_hit_beyond_min: assert property (@(posedge clk) disable iff (rst)
    (ov && od.hit) |-> (od.hit_distance > min_distance))
    else $error("hit distance not beyond minimum");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && !od.hit) |-> (od.hit_distance == '0))
    else $error("miss with nonzero distance");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!adv) |=> ($stable(sv[NV]) && $stable(sv[1])))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!ov && !sv[1]))
    else $error("valid bits set after reset");

endmodule
